// File: src/crc16r_pkg.sv
// Shared widths, register indexes, reset values and types for the reflected CRC-16 block.
// No dependencies.
package crc16r_pkg;

  localparam int CRC_W      = 16;
  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL = 2'd1;

  // reset values
  localparam logic [CRC_W-1:0] INIT_VALUE_RST = 16'hFFFF;
  localparam logic [CRC_W-1:0] POLYNOMIAL_RST = 16'h8408;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [DATA_W-1:0] byte_t;

  // configuration seen by the datapath
  typedef struct packed {
    crc_t init_value;
    crc_t polynomial;
  } cfg_t;

endpackage

// File: src/crc16r_in_if.sv
// Byte request channel: valid/ready plus byte and frame flags.
// Depends on crc16r_pkg.
interface crc16r_in_if
  import crc16r_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  first_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

// File: src/crc16r_out_if.sv
// Result channel: valid/ready plus finished CRC.
// Depends on crc16r_pkg.
interface crc16r_out_if
  import crc16r_pkg::*;
();
  logic valid;
  logic ready;
  crc_t crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// File: src/crc16r_cfg.sv
// Configuration registers: initial value and reflected polynomial.
// Depends on crc16r_pkg.
module crc16r_cfg
  import crc16r_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  crc_t init_r, init_nxt;
  crc_t poly_r, poly_nxt;

  always_comb begin
    init_nxt = init_r;
    poly_nxt = poly_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_VALUE: init_nxt = cfg_data[CRC_W-1:0];
        REG_POLYNOMIAL: poly_nxt = cfg_data[CRC_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= INIT_VALUE_RST;
      poly_r <= POLYNOMIAL_RST;
    end else begin
      init_r <= init_nxt;
      poly_r <= poly_nxt;
    end
  end

  assign cfg.init_value = init_r;
  assign cfg.polynomial = poly_r;

endmodule

// File: src/crc16r_fold.sv
// Folds one byte into a reflected CRC, LSB first, as an 8-step XOR network.
// Depends on crc16r_pkg.
module crc16r_fold
  import crc16r_pkg::*;
(
  input  crc_t  crc_in,
  input  byte_t data_byte,
  input  crc_t  polynomial,
  output crc_t  crc_out
);

  always_comb begin
    crc_t crc;
    logic mix;
    crc = crc_in;
    for (int i = 0; i < DATA_W; i++) begin
      mix = crc[0] ^ data_byte[i];
      crc = {1'b0, crc[CRC_W-1:1]};
      if (mix) begin
        crc = crc ^ polynomial;
      end
    end
    crc_out = crc;
  end

endmodule

// File: src/crc16r_top_note.sv
// Reset-state holder for the running CRC between frame bytes.
// Depends on crc16r_pkg.
module crc16r_state
  import crc16r_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  logic last_byte,
  input  crc_t init_value,
  input  crc_t crc_folded,
  output crc_t running_crc
);

  crc_t run_r, run_nxt;

  // after a last byte the CRC reloads, so a following unflagged byte starts fresh
  always_comb begin
    run_nxt = run_r;
    if (advance) begin
      run_nxt = last_byte ? init_value : crc_folded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= INIT_VALUE_RST;
    end else begin
      run_r <= run_nxt;
    end
  end

  assign running_crc = run_r;

endmodule

// File: src/crc16_reflected_byte_stream.sv
// Reflected CRC-16 over a byte stream, LSB first, one byte per clock unless the
// input stage stalls, which it does only while a last byte waits on a full, unread
// output register. Each accepted byte lands in an input register, is folded from
// there into the running CRC (8-step XOR network) and, on a last byte, the CRC
// goes to the output register, which drives CRC valid. Throughput is one byte per
// cycle while nothing stalls. first_byte reloads from initial value; no final XOR.
// Registers: 0 = initial value (reset FFFF), 1 = reflected polynomial (reset 8408);
// other indexes are ignored. Write config only while idle.
module crc16_reflected_byte_stream
  import crc16r_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  crc16r_in_if.sink             in_ch,
  crc16r_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;

  // input register stage
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  s1_first_r;
  logic  s1_last_r;

  // output register stage
  logic  out_valid_r, out_valid_nxt;
  crc_t  out_crc_r;

  crc_t  running_crc;
  crc_t  crc_base;
  crc_t  crc_folded;
  logic  out_free;
  logic  s1_adv;
  logic  in_take;

  crc16r_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // frame start takes the configured seed, otherwise continue
  assign crc_base = s1_first_r ? cfg.init_value : running_crc;

  crc16r_fold u_fold (
    .crc_in     (crc_base),
    .data_byte  (s1_byte_r),
    .polynomial (cfg.polynomial),
    .crc_out    (crc_folded)
  );

  // a non-last byte never needs the output slot
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take  = in_ch.valid && in_ch.ready;

  crc16r_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_adv),
    .last_byte   (s1_last_r),
    .init_value  (cfg.init_value),
    .crc_folded  (crc_folded),
    .running_crc (running_crc)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_first_r <= in_ch.first_byte;
      s1_last_r  <= in_ch.last_byte;
    end
    if (s1_adv && s1_last_r) begin
      out_crc_r <= crc_folded;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.crc_value = out_crc_r;

endmodule

// File: sim/testbench.sv
// Self-checking bench for crc16_reflected_byte_stream: directed and random byte requests
// under several register settings, CRC results checked against a predictor in a scoreboard.
// Depends on crc16r_pkg, crc16r_in_if, crc16r_out_if and the block itself.
`timescale 1ns / 1ps

module testbench;
  import crc16r_pkg::*;

  // indexes that hit no register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  // extra settle time after the last predicted CRC has shown up
  localparam int SETTLE_CYCLES    = 4;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int NUM_PHASES       = 6;
  // timeout for the whole run, in ns; well beyond the slowest legal run
  localparam int TIMEOUT_NS       = 4_000_000;

  // ---------------------------------------------------------------------------
  // Scoreboard: mirrors the register file and the running CRC, predicts the
  // CRC on every last-byte request and holds it until the result shows up.
  // ---------------------------------------------------------------------------
  class crc_scoreboard;
    crc_t init_value;
    crc_t polynomial;
    crc_t running_crc;
    crc_t pending_crcs[$];
    int   errors;

    function new();
      init_value  = INIT_VALUE_RST;
      polynomial  = POLYNOMIAL_RST;
      running_crc = INIT_VALUE_RST;
      errors      = 0;
    endfunction

    // eight right shifts, data taken LSB first, poly mixed in on bit mismatch
    function crc_t fold_byte_lsb_first(crc_t crc, byte_t data);
      logic mix;
      for (int k = 0; k < DATA_W; k++) begin
        mix = crc[0] ^ data[k];
        crc = crc >> 1;
        if (mix) begin
          crc = crc ^ polynomial;
        end
      end
      return crc;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_INIT_VALUE: init_value = value;
        REG_POLYNOMIAL: polynomial = value;
        default: ;
      endcase
    endfunction

    // called at the edge where a byte request is accepted
    function void note_byte(byte_t data, logic first_byte, logic last_byte);
      crc_t crc;
      crc = fold_byte_lsb_first(first_byte ? init_value : running_crc, data);
      if (last_byte) begin
        pending_crcs.push_back(crc);
        running_crc = init_value;
      end else begin
        running_crc = crc;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] crc check: %s", $realtime, what);
    endtask

    task check_crc(crc_t got);
      crc_t want;
      if (pending_crcs.size() == 0) begin
        report_mismatch($sformatf("unexpected crc_value %04h", got));
      end else begin
        want = pending_crcs.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("crc_value %04h, predicted %04h", got, want));
        end
      end
    endtask

    function int pending();
      return pending_crcs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crc16r_in_if  byte_bus ();
  crc16r_out_if crc_bus ();

  crc_scoreboard crc_board;

  // idle odds, percent of cycles; changed per phase by the stimulus thread
  int send_idle_pct;
  int recv_idle_pct;

  // random frame generator state: bytes still to go in the current frame
  int frame_left;

  crc16_reflected_byte_stream i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (byte_bus.sink),
    .out_ch    (crc_bus.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: check on every accepted result, then redraw ready.
  // Values are read right at the edge, before any update of that edge lands.
  initial begin
    crc_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && crc_bus.valid && crc_bus.ready) begin
        crc_board.check_crc(crc_bus.crc_value);
      end
      crc_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Present one byte request and hold it until accepted. Valid is left high
  // after acceptance; the next call or a drain decides what it does next, so
  // valid never gets two updates in one step.
  task automatic send_byte(byte_t data, logic first_byte, logic last_byte);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.data_byte  <= data;
    byte_bus.first_byte <= first_byte;
    byte_bus.last_byte  <= last_byte;
    @(posedge clk);
    while (!byte_bus.ready) begin
      @(posedge clk);
    end
    crc_board.note_byte(data, first_byte, last_byte);
  endtask

  // Mostly well-formed frames with random bytes; a share of frames start
  // without the first flag (fresh start after a last byte), and about one
  // request in ten carries random flags.
  task automatic send_random_byte();
    byte_t data;
    logic  first_byte;
    logic  last_byte;
    int    pick;
    data = byte_t'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 10) begin
      first_byte = 1'($urandom_range(0, 1));
      last_byte  = 1'($urandom_range(0, 1));
      if (last_byte) begin
        frame_left = 0;
      end
    end else begin
      first_byte = 1'b0;
      if (frame_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          frame_left = 1;                         // single-byte frames
        end else if (pick < 90) begin
          frame_left = $urandom_range(2, 10);
        end else begin
          frame_left = $urandom_range(11, 48);
        end
        first_byte = ($urandom_range(0, 99) >= 15);
      end
      frame_left--;
      last_byte = (frame_left == 0);
    end
    send_byte(data, first_byte, last_byte);
  endtask

  // Drop valid, wait for every predicted CRC, then let the pipe settle.
  // A frame may still be open here; its partial CRC stays in the block.
  task automatic drain_requests();
    byte_bus.valid <= 1'b0;
    while (crc_board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; program_regs lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    crc_board.set_reg(idx, value);
  endtask

  task automatic program_regs(crc_t init_value, crc_t polynomial);
    write_reg(REG_INIT_VALUE, init_value);
    write_reg($urandom_range(0, 1) ? REG_UNUSED_3 : REG_UNUSED_2,
              CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(REG_POLYNOMIAL, polynomial);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // phase settings: zero/all-ones initial values with fixed polynomials first, then random values
  crc_t phase_init [4] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
  crc_t phase_poly [4] = '{16'h8408, 16'hA001, 16'h0000, 16'hFFFF};

  initial begin
    crc_board  = new();
    frame_left = 0;
    send_idle_pct = 31;
    recv_idle_pct = 85;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_INIT_VALUE;
    cfg_data            <= '0;
    byte_bus.valid      <= 1'b0;
    byte_bus.data_byte  <= '0;
    byte_bus.first_byte <= 1'b0;
    byte_bus.last_byte  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, reset register values ---
    // no first flag right after reset: continues from the reset CRC
    send_byte(8'h31, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    // single-byte frames at both data extremes
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // the usual "123456789" check string
    for (int k = 0; k < 9; k++) begin
      send_byte(byte_t'(8'h31 + k), k == 0, k == 8);
    end
    // fresh frame after a last byte, no first flag
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    // first flag again mid-frame restarts the CRC
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    // leave a frame open across the first register write
    send_byte(8'hFF, 1'b0, 1'b0);

    // --- random part: one register setting per phase ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 85;
      end else if (p < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_requests();
      if (p < 4) begin
        program_regs(phase_init[p], phase_poly[p]);
      end else begin
        program_regs(crc_t'($urandom_range(0, 65535)), crc_t'($urandom_range(0, 65535)));
      end
      repeat (RANDOM_PER_PHASE) send_random_byte();
    end

    drain_requests();
    if (crc_board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
